### rtl/core/ehn_pkg.sv
package ehn_pkg;

   localparam int MAX_WEIGHTS = 64;
   localparam int IDX_W       = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
   localparam int CNT_W       = $clog2(MAX_WEIGHTS + 1);

   localparam int ACT_W   = 16;
   localparam int WGT_W   = 16;
   localparam int RATE_W  = 16;
   localparam int SCALE_W = 15;
   localparam int SUM_W   = 22;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 16;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Divider: numerator is 2*|w*scale| + |sum|, denominator is 2*|sum|.
   localparam int DIV_N_W = 32;
   localparam int DIV_D_W = SUM_W + 1;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRE_THRESHOLD  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POST_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_RATE     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_SCALE   = 2'd3;

   localparam logic [ACT_W-1:0]   PRE_THRESHOLD_RST  = 16'd0;
   localparam logic [ACT_W-1:0]   POST_THRESHOLD_RST = 16'd0;
   localparam logic [RATE_W-1:0]  LEARN_RATE_RST     = 16'd66;
   localparam logic [SCALE_W-1:0] WEIGHT_SCALE_RST   = 15'd4096;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_MUL1  = 9'b000000010,
      S_MUL2  = 9'b000000100,
      S_UPD   = 9'b000001000,
      S_STORE = 9'b000010000,
      S_RD    = 9'b000100000,
      S_RDW   = 9'b001000000,
      S_NPREP = 9'b010000000,
      S_DIV   = 9'b100000000
   } state_type;

endpackage

### rtl/core/ehn_ram.sv
module ehn_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/ehn_mul.sv
module ehn_mul (
   input  logic                         clock,
   input  logic [ehn_pkg::MUL_A_W-1:0]  op_a,
   input  logic [ehn_pkg::MUL_B_W-1:0]  op_b,
   output logic [ehn_pkg::MUL_P_W-1:0]  product
);

   logic [ehn_pkg::MUL_P_W-1:0] product_ff;
   logic [ehn_pkg::MUL_P_W-1:0] product_in;

   assign product_in = {{ehn_pkg::MUL_B_W{1'b0}}, op_a} * {{ehn_pkg::MUL_A_W{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

### rtl/core/ehn_div.sv
module ehn_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ehn_pkg::DIV_N_W-1:0]  numerator,
   input  logic [ehn_pkg::DIV_D_W-1:0]  denominator,
   output logic                         done,
   output logic [ehn_pkg::DIV_N_W-1:0]  quotient
);

   localparam int STEP_W = $clog2(ehn_pkg::DIV_N_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ehn_pkg::DIV_N_W - 1);

   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic [STEP_W-1:0]            step_ff, step_in;
   logic [ehn_pkg::DIV_D_W-1:0]  rem_ff, rem_in;
   logic [ehn_pkg::DIV_D_W-1:0]  den_ff, den_in;
   logic [ehn_pkg::DIV_N_W-1:0]  nq_ff, nq_in;
   logic [ehn_pkg::DIV_D_W:0]    trial;

   // One quotient bit per cycle: the numerator shifts out of the top of nq_ff
   // while quotient bits shift in at the bottom.
   assign trial = {rem_ff, nq_ff[ehn_pkg::DIV_N_W-1]};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      nq_in   = nq_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         rem_in  = '0;
         den_in  = denominator;
         nq_in   = numerator;
      end else if (run_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = ehn_pkg::DIV_D_W'(trial - {1'b0, den_ff});
            nq_in  = {nq_ff[ehn_pkg::DIV_N_W-2:0], 1'b1};
         end else begin
            rem_in = trial[ehn_pkg::DIV_D_W-1:0];
            nq_in  = {nq_ff[ehn_pkg::DIV_N_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      nq_ff  <= nq_in;
   end

   assign done     = done_ff;
   assign quotient = nq_ff;

endmodule

### rtl/core/efferent_hebb_normalize_core.sv
// Normalized Hebbian weight update, one source node at a time.
// A request is taken at a rising edge with start high and busy low. It carries
// one outgoing weight of the current node with both activities, a learn flag
// and a last-of-node mark. A request whose weight is updated passes S_MUL1,
// S_MUL2 and S_UPD before S_STORE, since the update goes twice through the
// shared multiplier; one that is not goes straight to S_STORE. busy stays high meanwhile.
// The request marked last (or the one that fills the 64-entry buffer) then
// plays out every weight of the node from the weight RAM, one result per
// strobe on rsp_valid for a single cycle, with rsp_last_out on the final one.
// A weight that is passed through is read in S_RD and S_RDW; a normalized weight
// then goes through the 32-step divider (S_NPREP, S_DIV) after one multiply.
// busy drops in the cycle that carries the last result.
// Results cannot be stalled: each is valid for exactly one cycle.
// The csr channel writes the thresholds, learning rate and scale; csr_ready
// is always high and writes belong only to idle periods.
// Synchronous reset restores the register defaults and clears the weight
// count and the running sum. The weight RAM is not cleared; only entries
// written for the current node are read.
module efferent_hebb_normalize_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [ehn_pkg::ACT_W-1:0]      req_source_activity,
   input  logic [ehn_pkg::ACT_W-1:0]      req_dest_activity,
   input  logic signed [ehn_pkg::WGT_W-1:0] req_weight_in,
   input  logic                           req_learnable,
   input  logic                           req_last_of_node,
   output logic                           rsp_valid,
   output logic signed [ehn_pkg::WGT_W-1:0] rsp_weight_out,
   output logic                           rsp_last_out,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ehn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]                    csr_wdata
);

   localparam int WGT_W = ehn_pkg::WGT_W;
   localparam int SUM_W = ehn_pkg::SUM_W;
   localparam int IDX_W = ehn_pkg::IDX_W;
   localparam int CNT_W = ehn_pkg::CNT_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ehn_pkg::MAX_WEIGHTS);

   function automatic logic signed [WGT_W-1:0] sat16(input logic signed [WGT_W+1:0] v);
      if (v > 18'sd32767) begin
         sat16 = 16'sh7fff;
      end else if (v < -18'sd32768) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = v[WGT_W-1:0];
      end
   endfunction

   function automatic logic signed [SUM_W-1:0] sat22(input logic signed [SUM_W:0] v);
      if (v > 23'sd2097151) begin
         sat22 = 22'sh1fffff;
      end else if (v < -23'sd2097152) begin
         sat22 = 22'sh200000;
      end else begin
         sat22 = v[SUM_W-1:0];
      end
   endfunction

   ehn_pkg::state_type state_ff, state_in;

   logic [ehn_pkg::ACT_W-1:0]   pre_th_ff, pre_th_in;
   logic [ehn_pkg::ACT_W-1:0]   post_th_ff, post_th_in;
   logic [ehn_pkg::RATE_W-1:0]  rate_ff, rate_in;
   logic [ehn_pkg::SCALE_W-1:0] scale_ff, scale_in;

   logic [CNT_W-1:0]            count_ff, count_in;
   logic signed [SUM_W-1:0]     sum_ff, sum_in;
   logic [CNT_W-1:0]            n_ff, n_in;
   logic [IDX_W-1:0]            k_ff, k_in;
   logic [SUM_W-1:0]            asum_ff, asum_in;

   logic [15:0]                 dpre_mag_ff, dpre_mag_in;
   logic [15:0]                 dpost_mag_ff, dpost_mag_in;
   logic                        neg_ff, neg_in;
   logic signed [WGT_W-1:0]     w_ff, w_in;
   logic                        learn_ff, learn_in;
   logic                        last_ff, last_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [WGT_W-1:0]     rsp_weight_ff, rsp_weight_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic signed [16:0]          dpre, dpost;
   logic                        do_update;
   logic [ehn_pkg::MUL_A_W-1:0] mul_a;
   logic [ehn_pkg::MUL_B_W-1:0] mul_b;
   logic [ehn_pkg::MUL_P_W-1:0] mul_p;
   logic [ehn_pkg::MUL_P_W:0]   rounded;
   logic signed [17:0]          delta;
   logic signed [WGT_W-1:0]     w_upd;
   logic [CNT_W-1:0]            count_next;
   logic                        ram_wr, ram_rd;
   logic [WGT_W:0]              ram_q;
   logic signed [WGT_W-1:0]     rd_w;
   logic                        rd_learn;
   logic                        emit_last;
   logic                        div_start, div_done;
   logic [ehn_pkg::DIV_N_W-1:0] div_num, div_q;
   logic [ehn_pkg::DIV_D_W-1:0] div_den;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ehn_pkg::S_IDLE);

   assign dpre  = $signed({1'b0, req_source_activity}) - $signed({1'b0, pre_th_ff});
   assign dpost = $signed({1'b0, req_dest_activity}) - $signed({1'b0, post_th_ff});
   assign do_update = req_learnable &&
                      ((!dpre[16] && (dpre != 17'sd0)) || (!dpost[16] && (dpost != 17'sd0)));

   // Round the Q0.48 magnitude to Q3.12, half away from zero.
   assign rounded = {1'b0, mul_p} + (49'd1 << 35);
   assign delta   = neg_ff ? -$signed({5'b0, rounded[48:36]}) : $signed({5'b0, rounded[48:36]});
   assign w_upd   = sat16(18'(w_ff) + delta);

   assign count_next = count_ff + 1'b1;
   assign rd_w       = ram_q[WGT_W-1:0];
   assign rd_learn   = ram_q[WGT_W];
   assign emit_last  = (CNT_W'(k_ff) + 1'b1) == n_ff;

   assign div_num = {mul_p[30:0], 1'b0} + {10'b0, asum_ff};
   assign div_den = {asum_ff, 1'b0};

   always_comb begin
      case (state_ff)
         ehn_pkg::S_MUL1: begin
            mul_a = dpre_mag_ff;
            mul_b = {16'b0, dpost_mag_ff};
         end
         ehn_pkg::S_MUL2: begin
            mul_a = rate_ff;
            mul_b = mul_p[31:0];
         end
         default: begin
            mul_a = rd_w[WGT_W-1] ? 16'(-rd_w) : 16'(rd_w);
            mul_b = {17'b0, scale_ff};
         end
      endcase
   end

   always_comb begin
      pre_th_in  = pre_th_ff;
      post_th_in = post_th_ff;
      rate_in    = rate_ff;
      scale_in   = scale_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ehn_pkg::CSR_PRE_THRESHOLD:  pre_th_in  = csr_wdata;
            ehn_pkg::CSR_POST_THRESHOLD: post_th_in = csr_wdata;
            ehn_pkg::CSR_LEARN_RATE:     rate_in    = csr_wdata;
            ehn_pkg::CSR_WEIGHT_SCALE:   scale_in   = csr_wdata[ehn_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      asum_in       = asum_ff;
      dpre_mag_in   = dpre_mag_ff;
      dpost_mag_in  = dpost_mag_ff;
      neg_in        = neg_ff;
      w_in          = w_ff;
      learn_in      = learn_ff;
      last_in       = last_ff;
      rsp_valid_in  = 1'b0;
      rsp_weight_in = rsp_weight_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr        = 1'b0;
      ram_rd        = 1'b0;
      div_start     = 1'b0;

      unique case (state_ff)
         ehn_pkg::S_IDLE: begin
            if (start) begin
               dpre_mag_in  = dpre[16] ? 16'(-dpre) : dpre[15:0];
               dpost_mag_in = dpost[16] ? 16'(-dpost) : dpost[15:0];
               neg_in       = dpre[16] ^ dpost[16];
               w_in         = req_weight_in;
               learn_in     = req_learnable;
               last_in      = req_last_of_node;
               state_in     = do_update ? ehn_pkg::S_MUL1 : ehn_pkg::S_STORE;
            end
         end
         ehn_pkg::S_MUL1: state_in = ehn_pkg::S_MUL2;
         ehn_pkg::S_MUL2: state_in = ehn_pkg::S_UPD;
         ehn_pkg::S_UPD: begin
            w_in     = w_upd;
            sum_in   = sat22(23'(sum_ff) + 23'(w_upd));
            state_in = ehn_pkg::S_STORE;
         end
         ehn_pkg::S_STORE: begin
            ram_wr = 1'b1;
            if (last_ff || (count_next == CNT_FULL)) begin
               n_in     = count_next;
               k_in     = '0;
               asum_in  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
               state_in = ehn_pkg::S_RD;
            end else begin
               count_in = count_next;
               state_in = ehn_pkg::S_IDLE;
            end
         end
         ehn_pkg::S_RD: begin
            ram_rd   = 1'b1;
            state_in = ehn_pkg::S_RDW;
         end
         ehn_pkg::S_RDW: begin
            neg_in = rd_w[WGT_W-1];
            if (rd_learn && (asum_ff != '0)) begin
               state_in = ehn_pkg::S_NPREP;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_weight_in = rd_w;
               rsp_last_in   = emit_last;
               if (emit_last) begin
                  count_in = '0;
                  sum_in   = '0;
                  state_in = ehn_pkg::S_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ehn_pkg::S_RD;
               end
            end
         end
         ehn_pkg::S_NPREP: begin
            div_start = 1'b1;
            state_in  = ehn_pkg::S_DIV;
         end
         ehn_pkg::S_DIV: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  rsp_weight_in = (div_q > 32'd32768) ? 16'sh8000 : 16'(-div_q);
               end else begin
                  rsp_weight_in = (div_q > 32'd32767) ? 16'sh7fff : div_q[WGT_W-1:0];
               end
               rsp_last_in = emit_last;
               if (emit_last) begin
                  count_in = '0;
                  sum_in   = '0;
                  state_in = ehn_pkg::S_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ehn_pkg::S_RD;
               end
            end
         end
         default: state_in = ehn_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ehn_pkg::S_IDLE;
         pre_th_ff    <= ehn_pkg::PRE_THRESHOLD_RST;
         post_th_ff   <= ehn_pkg::POST_THRESHOLD_RST;
         rate_ff      <= ehn_pkg::LEARN_RATE_RST;
         scale_ff     <= ehn_pkg::WEIGHT_SCALE_RST;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pre_th_ff    <= pre_th_in;
         post_th_ff   <= post_th_in;
         rate_ff      <= rate_in;
         scale_ff     <= scale_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff          <= n_in;
      k_ff          <= k_in;
      asum_ff       <= asum_in;
      dpre_mag_ff   <= dpre_mag_in;
      dpost_mag_ff  <= dpost_mag_in;
      neg_ff        <= neg_in;
      w_ff          <= w_in;
      learn_ff      <= learn_in;
      last_ff       <= last_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_last_ff   <= rsp_last_in;
   end

   ehn_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   ehn_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .done        (div_done),
      .quotient    (div_q)
   );

   ehn_ram #(
      .WIDTH (WGT_W + 1),
      .DEPTH (ehn_pkg::MAX_WEIGHTS)
   ) u_wbuf (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({learn_ff, w_ff}),
      .rd_en   (ram_rd),
      .rd_addr (k_ff),
      .rd_data (ram_q)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_weight_out = rsp_weight_ff;
   assign rsp_last_out   = rsp_last_ff;

endmodule
